FILE: rtl/radix_digit_emitter_core_macros.svh
// Assertion macros shared by the checker of the radix digit emitter.
`ifndef RADIX_DIGIT_EMITTER_CORE_MACROS_SVH
`define RADIX_DIGIT_EMITTER_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define RDE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define RDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rde_pkg.sv
// Package of the radix digit emitter: sizes, register codes and the digit table lookup.
`timescale 1ns / 1ps
package rde_pkg;

  localparam int unsigned VALUE_BITS  = 64;
  localparam int unsigned MAX_RADIX   = 16;
  localparam int unsigned MIN_RADIX   = 2;
  localparam int unsigned MAX_DIGITS  = VALUE_BITS;

  // Bits of the dividend consumed per cycle of the shared divider.
  localparam int unsigned STEP_BITS   = 8;
  localparam int unsigned PASS_CYCLES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int unsigned PAD_BITS    = PASS_CYCLES * STEP_BITS;
  localparam int unsigned STEP_CNT_W  = (PASS_CYCLES > 1) ? $clog2(PASS_CYCLES) : 1;

  localparam int unsigned IN_W        = 64;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned RADIX_W     = 5;
  localparam int unsigned REM_W       = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int unsigned TAB_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RADIX      = 2'd0,
    REG_CHARS_LOW  = 2'd1,
    REG_CHARS_HIGH = 2'd2
  } cfg_reg_e;

  localparam logic [RADIX_W-1:0]    RESET_RADIX      = 5'd10;
  localparam logic [CFG_DATA_W-1:0] RESET_CHARS_LOW  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0] RESET_CHARS_HIGH = 64'h6665_6463_6261_3938;

  // Clamp the radix register into the supported range.
  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_W'(MIN_RADIX)) res = RADIX_W'(MIN_RADIX);
    if (r > RADIX_W'(MAX_RADIX)) res = RADIX_W'(MAX_RADIX);
    return res;
  endfunction

  // Pick the character byte of a digit out of the two table words.
  function automatic logic [CHAR_W-1:0] table_char(
    input logic [TAB_IDX_W-1:0]  d,
    input logic [CFG_DATA_W-1:0] lo,
    input logic [CFG_DATA_W-1:0] hi
  );
    logic [CFG_DATA_W-1:0] word;
    word = d[TAB_IDX_W-1] ? hi : lo;
    return word[d[TAB_IDX_W-2:0]*CHAR_W +: CHAR_W];
  endfunction

endpackage

FILE: rtl/radix_digit_emitter_core.sv
// Top level of the radix digit emitter: shared divider, digit stack and output register.
`timescale 1ns / 1ps
// Usage
//   Input channel: in_valid_i / in_stall_o / value_i. One transaction carries one
//   unsigned value; in_stall_o is high from the cycle after acceptance until the
//   last digit of that value has been loaded into the output register.
//   Output channel: out_valid_o / out_stall_i with digit_char_o, digit_count_o and
//   last_o. One transaction per digit, most significant first; last_o marks the
//   least significant digit. Zero gives a single digit from table entry 0.
//   Configuration: cfg_we_i / cfg_index_i / cfg_data_i, written while idle only.
//   Index 0 is the radix (clamped to 2..16 when used), 1 and 2 the digit tables.
// Division and emission
//   Each digit takes one pass of the shared divider, which retires STEP_BITS (8)
//   quotient bits per cycle through a chain of narrow subtractors. A value is
//   divided down to all of its digits before the first is emitted: up to 64
//   digits for a binary value, 20 for a full 64-bit value in decimal.
// Reset and stall
//   Reset clears the sequencer and the output valid and loads the reset radix and
//   tables. While out_valid_o is high and out_stall_i is high the output holds and
//   the digit stack waits; the next input may be taken while the final digit is
//   still waiting in the output register.
module radix_digit_emitter_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [rde_pkg::IN_W-1:0]        value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rde_pkg::CHAR_W-1:0]      digit_char_o,
  output logic [rde_pkg::COUNT_W-1:0]     digit_count_o,
  output logic                            last_o,
  input  logic                            cfg_we_i,
  input  logic [rde_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [rde_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import rde_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_e;

  // Sequencer and datapath registers.
  state_e                  state_q, state_d;
  logic [PAD_BITS-1:0]     n_q, n_d;         // dividend, becomes the quotient over a pass
  logic [REM_W-1:0]        rem_q, rem_d;     // running remainder of the pass
  logic [STEP_CNT_W-1:0]   step_q, step_d;   // cycle within the pass
  logic [REM_W-1:0]        stack_q [MAX_DIGITS];
  logic [REM_W-1:0]        stack_d [MAX_DIGITS];
  logic [COUNT_W-1:0]      cnt_q, cnt_d;     // digits found so far
  logic [COUNT_W-1:0]      left_q, left_d;   // digits still to emit

  // Output register.
  logic                    out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]       out_char_q, out_char_d;
  logic [COUNT_W-1:0]      out_cnt_q, out_cnt_d;
  logic                    out_last_q, out_last_d;

  // Configuration registers.
  logic [RADIX_W-1:0]      radix_q;
  logic [CFG_DATA_W-1:0]   chars_lo_q;
  logic [CFG_DATA_W-1:0]   chars_hi_q;

  // Shared divider step.
  logic [RADIX_W-1:0]      radix_eff;
  logic [STEP_BITS-1:0]    chunk;
  logic [STEP_BITS-1:0]    qbits;
  logic [REM_W-1:0]        rem_step;
  logic [REM_W:0]          trial;
  logic [PAD_BITS-1:0]     quot;
  logic                    pass_end;
  logic                    in_acc;
  logic                    out_free;
  logic                    pop;

  assign radix_eff = eff_radix(radix_q);
  assign chunk     = n_q[PAD_BITS-1 -: STEP_BITS];

  // Restoring division of the top chunk, one bit per link of the chain.
  always_comb begin
    rem_step = rem_q;
    qbits    = '0;
    trial    = '0;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      trial = {rem_step, chunk[i]};
      if ((RADIX_W + 1)'(trial) >= (RADIX_W + 1)'(radix_eff)) begin
        qbits[i] = 1'b1;
        rem_step = REM_W'((RADIX_W + 1)'(trial) - (RADIX_W + 1)'(radix_eff));
      end else begin
        rem_step = trial[REM_W-1:0];
      end
    end
  end

  // Shift the quotient bits in at the bottom; after a full pass n holds n / radix.
  assign quot     = (n_q << STEP_BITS) | PAD_BITS'(qbits);
  assign pass_end = (step_q == STEP_CNT_W'(PASS_CYCLES - 1));
  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign pop      = (state_q == S_EMIT) && out_free;

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    rem_d       = rem_q;
    step_d      = step_q;
    stack_d     = stack_q;
    cnt_d       = cnt_q;
    left_d      = left_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_char_d  = out_char_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          // Drop bits above VALUE_BITS.
          n_d     = PAD_BITS'(value_i[VALUE_BITS-1:0]);
          rem_d   = '0;
          step_d  = '0;
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        n_d    = quot;
        rem_d  = rem_step;
        step_d = step_q + 1'b1;
        if (pass_end) begin
          // Push the digit; the newest one sits at the top of the stack.
          stack_d[0] = rem_step;
          for (int i = 1; i < MAX_DIGITS; i++) stack_d[i] = stack_q[i-1];
          cnt_d  = cnt_q + 1'b1;
          rem_d  = '0;
          step_d = '0;
          if (quot == '0 || cnt_q == COUNT_W'(MAX_DIGITS - 1)) begin
            left_d  = cnt_q + 1'b1;
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (pop) begin
          // Pop the most significant pending digit into the output register.
          out_valid_d = 1'b1;
          out_char_d  = table_char(TAB_IDX_W'(stack_q[0]), chars_lo_q, chars_hi_q);
          out_cnt_d   = cnt_q;
          out_last_d  = (left_q == COUNT_W'(1));
          for (int i = 0; i < MAX_DIGITS - 1; i++) stack_d[i] = stack_q[i+1];
          left_d = left_q - 1'b1;
          if (left_q == COUNT_W'(1)) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      radix_q     <= RESET_RADIX;
      chars_lo_q  <= RESET_CHARS_LOW;
      chars_hi_q  <= RESET_CHARS_HIGH;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_RADIX:      radix_q    <= cfg_data_i[RADIX_W-1:0];
          REG_CHARS_LOW:  chars_lo_q <= cfg_data_i;
          REG_CHARS_HIGH: chars_hi_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Datapath and payload registers hold without reset.
  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    rem_q      <= rem_d;
    step_q     <= step_d;
    stack_q    <= stack_d;
    cnt_q      <= cnt_d;
    left_q     <= left_d;
    out_char_q <= out_char_d;
    out_cnt_q  <= out_cnt_d;
    out_last_q <= out_last_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign digit_char_o  = out_char_q;
  assign digit_count_o = out_cnt_q;
  assign last_o        = out_last_q;

endmodule

FILE: rtl/rde_checker.sv
// Port-level checker of the radix digit emitter and its bind.
`timescale 1ns / 1ps
`include "radix_digit_emitter_core_macros.svh"
module rde_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic [rde_pkg::IN_W-1:0]        value_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [rde_pkg::CHAR_W-1:0]      digit_char_o,
  input logic [rde_pkg::COUNT_W-1:0]     digit_count_o,
  input logic                            last_o,
  input logic                            cfg_we_i,
  input logic [rde_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input logic [rde_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import rde_pkg::*;

  logic in_acc;
  logic out_acc;
  logic unused_ok;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_acc   = out_valid_o && !out_stall_i;
  assign unused_ok = ^{value_i, cfg_we_i, cfg_index_i, cfg_data_i};

  // Busy right after taking a value.
  `RDE_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall_o, "input not stalled after accept")
  // Digit count always in range.
  `RDE_ASSERT_IMPL(a_count_range, out_valid_o,
    digit_count_o != '0 && digit_count_o <= COUNT_W'(MAX_DIGITS), "digit count out of range")
  // Digits of one value follow back to back and share their count.
  `RDE_ASSERT_NEXT(a_digits_contiguous, out_acc && !last_o,
    out_valid_o && $stable(digit_count_o), "gap or count change inside a value")
  // A stalled digit holds.
  `RDE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(digit_char_o) && $stable(last_o), "stalled digit changed")

endmodule

bind radix_digit_emitter_core rde_checker u_rde_checker (.*);

FILE: verif/radix_digit_emitter_core_tb.sv
// Self-checking testbench for radix_digit_emitter_core: random values against a digit predictor.
`timescale 1ns / 1ps
module radix_digit_emitter_core_tb;
  import rde_pkg::*;

  localparam int unsigned RESET_CYCLES   = 8;
  localparam int unsigned NUM_PHASES     = 10;
  localparam int unsigned VALUES_PER_PHASE = 26;
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned DRAIN_CYCLES   = 600;
  localparam int unsigned LONG_HOLD_AT   = 150;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT    = 2_000_000;

  // Index past the register list; writes to it must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic [COUNT_W-1:0] count;
    logic               last;
  } digit_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic [IN_W-1:0]        value_i     = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [CHAR_W-1:0]      digit_char_o;
  logic [COUNT_W-1:0]     digit_count_o;
  logic                   last_o;
  logic                   cfg_we_i    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i = REG_RADIX;
  logic [CFG_DATA_W-1:0]  cfg_data_i  = '0;

  // Shadow copy of the configuration registers.
  logic [RADIX_W-1:0]    radix_reg  = RESET_RADIX;
  logic [CFG_DATA_W-1:0] chars_low  = RESET_CHARS_LOW;
  logic [CFG_DATA_W-1:0] chars_high = RESET_CHARS_HIGH;

  logic [IN_W-1:0] values_to_send [$];
  digit_t          digits_due [$];

  bit          idle_on = 1'b1;
  int unsigned send_gap_left = 0;
  int unsigned hold_left = 0;
  bit          long_hold_done = 1'b0;
  int unsigned digits_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  always #5 clk_i = ~clk_i;

  radix_digit_emitter_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .digit_char_o  (digit_char_o),
    .digit_count_o (digit_count_o),
    .last_o        (last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  function automatic logic [IN_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Radix actually in use: out-of-range register contents saturate to 2..16.
  function automatic logic [IN_W-1:0] active_base();
    if (radix_reg < RADIX_W'(MIN_RADIX)) return IN_W'(MIN_RADIX);
    if (radix_reg > RADIX_W'(MAX_RADIX)) return IN_W'(MAX_RADIX);
    return IN_W'(radix_reg);
  endfunction

  function automatic logic [CHAR_W-1:0] char_of(input logic [TAB_IDX_W-1:0] d);
    return CHAR_W'({chars_high, chars_low} >> (d * CHAR_W));
  endfunction

  // Divide down to the digits, then queue them most significant first.
  function automatic void predict_digits(input logic [IN_W-1:0] value);
    logic [IN_W-1:0]      rest;
    logic [IN_W-1:0]      base;
    logic [TAB_IDX_W-1:0] digs [MAX_DIGITS];
    int                   n;
    digit_t               d;
    base = active_base();
    rest = value;
    n = 0;
    do begin
      digs[n] = TAB_IDX_W'(rest % base);
      rest = rest / base;
      n++;
    end while (rest != 0 && n < MAX_DIGITS);
    for (int k = 0; k < n; k++) begin
      d.ch    = char_of(digs[n - 1 - k]);
      d.count = COUNT_W'(n);
      d.last  = (k == n - 1);
      digits_due.push_back(d);
    end
  endfunction

  // Zero, all ones, powers of the radix and one below them, short and random-width values, full width.
  function automatic logic [IN_W-1:0] pick_value();
    logic [IN_W-1:0] v;
    logic [IN_W-1:0] base;
    int unsigned     kind;
    base = active_base();
    kind = $urandom_range(0, 9);
    case (kind)
      0: v = '0;
      1: v = '1;
      2: begin
        v = IN_W'(1);
        repeat ($urandom_range(1, 24)) begin
          if (v <= {IN_W{1'b1}} / base) v = v * base;
        end
        v = v - IN_W'($urandom_range(0, 1));
      end
      3, 4, 5: v = rand64() >> (IN_W - $urandom_range(1, 12));
      6, 7:    v = rand64() >> (IN_W - $urandom_range(1, 64));
      default: v = rand64();
    endcase
    return v;
  endfunction

  task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endtask

  // Drive one register write; the caller drops the write enable after the group.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      REG_RADIX:      radix_reg  = data[RADIX_W-1:0];
      REG_CHARS_LOW:  chars_low  = data;
      REG_CHARS_HIGH: chars_high = data;
      default: ;
    endcase
  endtask

  // Radix data carries random upper bits that the register must drop.
  task automatic set_radix(input int unsigned r);
    write_reg(REG_RADIX, {(CFG_DATA_W - RADIX_W)'(rand64()), RADIX_W'(r)});
  endtask

  task automatic configure_phase(input int unsigned ph);
    case (ph)
      1: begin
        set_radix(2);
        write_reg(REG_CHARS_LOW, rand64());
        write_reg(REG_CHARS_HIGH, rand64());
      end
      2: begin
        set_radix(MAX_RADIX);
        write_reg(REG_CHARS_LOW, '0);
        write_reg(REG_CHARS_HIGH, '1);
      end
      3: begin
        set_radix(0);
        write_reg(REG_UNUSED, rand64());
        write_reg(REG_CHARS_LOW, rand64());
        write_reg(REG_CHARS_HIGH, rand64());
      end
      4: set_radix(31);
      5: set_radix(1);
      6: begin
        set_radix(MAX_RADIX + 1);
        write_reg(REG_CHARS_HIGH, rand64());
      end
      7: set_radix(3);
      NUM_PHASES - 1: begin
        set_radix(RESET_RADIX);
        write_reg(REG_CHARS_LOW, RESET_CHARS_LOW);
        write_reg(REG_CHARS_HIGH, RESET_CHARS_HIGH);
      end
      default: begin
        set_radix($urandom_range(0, 31));
        write_reg(REG_CHARS_LOW, rand64());
        write_reg(REG_CHARS_HIGH, rand64());
      end
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Block until every queued value is taken and every digit has come back.
  task automatic wait_idle();
    do @(negedge clk_i); while (values_to_send.size() != 0 || digits_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Sender: hold a stalled transaction, otherwise idle in bursts or offer the next value.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        predict_digits(value_i);
        void'(values_to_send.pop_front());
      end
      if (send_gap_left > 0) begin
        send_gap_left--;
        in_valid_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        send_gap_left = $urandom_range(1, 11) - 1;
        in_valid_i <= 1'b0;
      end else if (values_to_send.size() != 0) begin
        in_valid_i <= 1'b1;
        value_i    <= values_to_send[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: check each accepted digit, stall in bursts, and once hold off long.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        digits_seen++;
        if (digits_due.size() == 0) begin
          report("unexpected digit", 64'(digit_char_o), 64'(digit_char_o));
        end else begin
          digit_t want;
          want = digits_due.pop_front();
          if (digit_char_o !== want.ch)
            report("digit_char", 64'(want.ch), 64'(digit_char_o));
          if (digit_count_o !== want.count)
            report("digit_count", 64'(want.count), 64'(digit_count_o));
          if (last_o !== want.last)
            report("last", 64'(want.last), 64'(last_o));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!long_hold_done && digits_seen >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 11) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Decimal corner values under the reset table: zero, digit rollovers, all-ones,
    // sign-bit patterns and the largest power of ten that fits.
    values_to_send = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd11, 64'd99, 64'd100,
                       64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                       64'h7FFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555,
                       64'hAAAA_AAAA_AAAA_AAAA, 64'h8AC7_2304_89E8_0000,
                       64'h8AC7_2304_89E7_FFFF};
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        wait_idle();
        if (ph == NUM_PHASES - 1) idle_on = 1'b0;
        configure_phase(ph);
      end
      repeat (VALUES_PER_PHASE) values_to_send.push_back(pick_value());
    end
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: radix_digit_emitter_core.f
+incdir+rtl
rtl/rde_pkg.sv
rtl/radix_digit_emitter_core.sv
rtl/rde_checker.sv
verif/radix_digit_emitter_core_tb.sv
